FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the step pulse generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define SSPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SSPG_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define SSPG_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSPG_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/sspg_pkg.sv
// Package for the stepper step pulse generator: field widths, command codes
// and parameter defaults. No dependencies.
package sspg_pkg;

  // Payload widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STEPS_W    = 24;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned HALF_W     = 19;
  localparam int unsigned POS_IO_W   = 32;

  // Largest half period the timer holds
  localparam logic [HALF_W-1:0] HALF_MAX = {HALF_W{1'b1}};

  // Parameter defaults
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
  localparam int unsigned POSITION_WIDTH_DEF   = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET_POS = 2'd3;

endpackage

FILE: hw/rtl/sspg_req_if.sv
// Command request channel of the step pulse generator (valid/ready).
// Depends on sspg_pkg for field widths.
interface sspg_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sspg_pkg::CMD_W-1:0]           cmd;
  logic                                 move_direction;
  logic [sspg_pkg::STEPS_W-1:0]         move_steps;
  logic [sspg_pkg::RATE_W-1:0]          steps_per_second;
  logic                                 limit_min_pressed;
  logic                                 limit_max_pressed;
  logic signed [sspg_pkg::POS_IO_W-1:0] new_position;

  modport source (
    output valid, cmd, move_direction, move_steps, steps_per_second,
           limit_min_pressed, limit_max_pressed, new_position,
    input  ready
  );

  modport sink (
    input  valid, cmd, move_direction, move_steps, steps_per_second,
           limit_min_pressed, limit_max_pressed, new_position,
    output ready
  );
endinterface

FILE: hw/rtl/sspg_rsp_if.sv
// Status response channel of the step pulse generator (valid/ready).
// Depends on sspg_pkg for field widths.
interface sspg_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 move_accepted;
  logic                                 step_out;
  logic                                 dir_out;
  logic signed [sspg_pkg::POS_IO_W-1:0] position;
  logic [sspg_pkg::STEPS_W-1:0]         remaining_steps;
  logic                                 busy_res;

  modport source (
    output valid, move_accepted, step_out, dir_out, position, remaining_steps, busy_res,
    input  ready
  );

  modport sink (
    input  valid, move_accepted, step_out, dir_out, position, remaining_steps, busy_res,
    output ready
  );
endinterface

FILE: hw/rtl/sspg_div.sv
// Radix-2 restoring divider: a constant tick rate divided by a step rate,
// one quotient bit per cycle. Depends on sspg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sspg_div #(
  parameter int unsigned TICKS_PER_SECOND = sspg_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned QUOT_W           = $clog2(TICKS_PER_SECOND + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sspg_pkg::RATE_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic [QUOT_W-1:0]               quot_o
);

  localparam int unsigned RW  = sspg_pkg::RATE_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QUOT_W-1:0] acc_q, acc_d;   // dividend bits shift out, quotient bits shift in
  logic [RW-1:0]     rem_q, rem_d;
  logic [RW-1:0]     dvs_q, dvs_d;
  logic [RW:0]       rem_sh;
  logic [RW:0]       diff;
  logic              qbit;

  // One shift-compare-subtract step
  always_comb begin
    rem_sh = {rem_q, acc_q[QUOT_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    qbit   = (rem_sh >= {1'b0, dvs_q});
  end

  // Load on start, then iterate until every quotient bit is in
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W);
      acc_d  = QUOT_W'(TICKS_PER_SECOND);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = {acc_q[QUOT_W-2:0], qbit};
      rem_d = qbit ? diff[RW-1:0] : rem_sh[RW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;

  `SSPG_ASSERT(a_div_cnt_live, clk_i, rst_ni, busy_q |-> (cnt_q != '0), "divider busy with no bits left")
  `SSPG_ASSERT(a_div_rem_below, clk_i, rst_ni, busy_q |-> (rem_q < dvs_q), "partial remainder not below divisor")
  `SSPG_ASSERT(a_div_start, clk_i, rst_ni, (start_i && !busy_q) |=> busy_q, "start did not launch divider")
  `SSPG_NEVER(a_div_restart, clk_i, rst_ni, start_i && busy_q, "divider started while busy")

endmodule

FILE: hw/rtl/stepper_step_pulse_generator_top.sv
// One stepper axis: step/direction pulse generator driven by command requests.
// Depends on sspg_pkg, sspg_req_if, sspg_rsp_if, sspg_div and assert_macros.svh.

// Each request is a tick, move, stop or set-position command and yields one
// response with the axis status after the command. Tick, stop, set-position
// and rejected moves are written to the response register when the request is
// taken. An accepted move runs the restoring divider, one quotient bit per
// cycle, to form the half period, and its response is loaded once the divide
// is done and the output register is free. The block takes no request while a
// move is in the divider; a response waiting in the output register does not
// hold back the next request when it is taken the same cycle.
`include "assert_macros.svh"

module stepper_step_pulse_generator_top #(
  parameter int unsigned TICKS_PER_SECOND = sspg_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned POSITION_WIDTH   = sspg_pkg::POSITION_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  sspg_req_if.sink    req_i,
  sspg_rsp_if.source  rsp_o
);

  localparam int unsigned QUOT_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned STEPS_W = sspg_pkg::STEPS_W;
  localparam int unsigned HALF_W  = sspg_pkg::HALF_W;
  localparam int unsigned PW      = POSITION_WIDTH;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic st_q, st_d;

  // Axis state
  logic               posdir_q;
  logic [PW-1:0]      pos_q, pos_d;
  logic [STEPS_W-1:0] steps_q, steps_d;
  logic               step_q, step_d;
  logic               stop_q, stop_d;
  logic               run_q, run_d;
  logic [HALF_W-1:0]  tcnt_q, tcnt_d;
  logic [HALF_W-1:0]  half_q, half_d;
  logic               movpos_q, movpos_d;
  logic               dir_q, dir_d;

  // Move held during the divide
  logic               mv_dir_q;
  logic [STEPS_W-1:0] mv_steps_q;
  logic               mv_pos_q;

  // Response register
  logic                                 ovld_q, ovld_d;
  logic                                 o_acc_q;
  logic                                 o_step_q;
  logic                                 o_dir_q;
  logic signed [sspg_pkg::POS_IO_W-1:0] o_pos_q;
  logic [STEPS_W-1:0]                   o_steps_q;
  logic                                 o_busy_q;

  logic              out_free, acc, load, acc_flag, div_start, div_busy;
  logic [QUOT_W-1:0] div_quot;
  logic [HALF_W-1:0] tinc;
  logic [STEPS_W-1:0] steps_dec;
  logic              pos_travel, move_ok;
  logic [31:0]       hp32;
  logic [HALF_W-1:0] half_new;

  assign out_free    = !ovld_q || rsp_o.ready;
  assign req_i.ready = (st_q == ST_IDLE) && out_free;
  assign acc         = req_i.valid && req_i.ready;

  sspg_div #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .QUOT_W           (QUOT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (req_i.steps_per_second),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  // Move checks and half period clamp
  always_comb begin
    pos_travel = (req_i.move_direction == posdir_q);
    move_ok    = (steps_q == '0) && (req_i.move_steps != '0) &&
                 (req_i.steps_per_second != '0) &&
                 !(pos_travel ? req_i.limit_max_pressed : req_i.limit_min_pressed);
    hp32       = 32'(div_quot >> 1);
    if (hp32 == 32'd0) begin
      half_new = HALF_W'(1);
    end else if (hp32 > 32'(sspg_pkg::HALF_MAX)) begin
      half_new = sspg_pkg::HALF_MAX;
    end else begin
      half_new = hp32[HALF_W-1:0];
    end
    tinc      = tcnt_q + HALF_W'(1);
    steps_dec = steps_q - STEPS_W'(1);
  end

  // Command execution
  always_comb begin
    st_d      = st_q;
    pos_d     = pos_q;
    steps_d   = steps_q;
    step_d    = step_q;
    stop_d    = stop_q;
    run_d     = run_q;
    tcnt_d    = tcnt_q;
    half_d    = half_q;
    movpos_d  = movpos_q;
    dir_d     = dir_q;
    load      = 1'b0;
    acc_flag  = 1'b0;
    div_start = 1'b0;
    if (st_q == ST_IDLE && acc) begin
      load = 1'b1;
      unique case (req_i.cmd)
        sspg_pkg::CMD_TICK: begin
          if (run_q) begin
            if (tinc >= half_q) begin
              tcnt_d = '0;
              if (steps_q == '0) begin
                stop_d  = 1'b0;
                run_d   = 1'b0;
                steps_d = '0;
                step_d  = 1'b0;
              end else begin
                step_d = !step_q;
                if (step_q) begin
                  // falling edge: count one step
                  pos_d   = movpos_q ? pos_q + PW'(1) : pos_q - PW'(1);
                  steps_d = steps_dec;
                end
                if (stop_q || (step_q && steps_dec == '0)) begin
                  stop_d  = 1'b0;
                  run_d   = 1'b0;
                  steps_d = '0;
                end
              end
            end else begin
              tcnt_d = tinc;
            end
          end
        end
        sspg_pkg::CMD_MOVE: begin
          if (move_ok) begin
            load      = 1'b0;
            div_start = 1'b1;
            st_d      = ST_DIV;
          end
        end
        sspg_pkg::CMD_STOP: begin
          if (step_q) begin
            stop_d = 1'b1;
          end else begin
            stop_d  = 1'b0;
            run_d   = 1'b0;
            steps_d = '0;
            step_d  = 1'b0;
          end
        end
        sspg_pkg::CMD_SET_POS: begin
          pos_d = PW'(req_i.new_position);
        end
        default: ;
      endcase
    end else if (st_q == ST_DIV && !div_busy && out_free) begin
      // Divide done: start motion
      dir_d    = mv_dir_q;
      movpos_d = mv_pos_q;
      steps_d  = mv_steps_q;
      tcnt_d   = '0;
      half_d   = half_new;
      run_d    = 1'b1;
      load     = 1'b1;
      acc_flag = 1'b1;
      st_d     = ST_IDLE;
    end
  end

  // Hold the response until taken
  always_comb begin
    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (rsp_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      posdir_q <= 1'b0;
      pos_q    <= '0;
      steps_q  <= '0;
      step_q   <= 1'b0;
      stop_q   <= 1'b0;
      run_q    <= 1'b0;
      tcnt_q   <= '0;
      half_q   <= '0;
      movpos_q <= 1'b0;
      dir_q    <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      if (cfg_we_i) begin
        posdir_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      steps_q  <= steps_d;
      step_q   <= step_d;
      stop_q   <= stop_d;
      run_q    <= run_d;
      tcnt_q   <= tcnt_d;
      half_q   <= half_d;
      movpos_q <= movpos_d;
      dir_q    <= dir_d;
      ovld_q   <= ovld_d;
    end
  end

  // Latch the move request and the response payload
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      mv_dir_q   <= req_i.move_direction;
      mv_steps_q <= req_i.move_steps;
      mv_pos_q   <= pos_travel;
    end
    if (load) begin
      o_acc_q   <= acc_flag;
      o_step_q  <= step_d;
      o_dir_q   <= dir_d;
      o_pos_q   <= sspg_pkg::POS_IO_W'($signed(pos_d));
      o_steps_q <= steps_d;
      o_busy_q  <= run_d;
    end
  end

  assign rsp_o.valid           = ovld_q;
  assign rsp_o.move_accepted   = o_acc_q;
  assign rsp_o.step_out        = o_step_q;
  assign rsp_o.dir_out         = o_dir_q;
  assign rsp_o.position        = o_pos_q;
  assign rsp_o.remaining_steps = o_steps_q;
  assign rsp_o.busy_res        = o_busy_q;

  `SSPG_ASSERT(a_run_steps, clk_i, rst_ni, run_q == (steps_q != '0), "timer state disagrees with step count")
  `SSPG_ASSERT(a_step_run, clk_i, rst_ni, step_q |-> run_q, "step high with timer halted")
  `SSPG_ASSERT(a_stop_high, clk_i, rst_ni, stop_q |-> step_q, "stop pending with step low")
  `SSPG_ASSERT(a_half_nz, clk_i, rst_ni, run_q |-> (half_q != '0), "timer running with zero half period")
  `SSPG_ASSERT(a_div_block, clk_i, rst_ni, (st_q == ST_DIV) |-> !req_i.ready, "request taken during divide")

endmodule
